/* hw/rtl/abdst_pkg.sv */
// Shared types, constants and helpers for the adaptive bus delay step tuner.
`default_nettype none
package abdst_pkg;

  localparam int BUS_COUNT_DEF     = 32;
  localparam int HISTORY_DEPTH_DEF = 20;
  localparam int STEP_COUNT        = 11;
  localparam logic [3:0] TOP_STEP  = 4'd10;

  localparam logic       ENABLE_RST   = 1'b0;
  localparam logic [4:0] LOOKBACK_RST = 5'd5;
  localparam logic [3:0] RELOAD_RST   = 4'd3;
  localparam logic [3:0] MAXTRY_RST   = 4'd10;
  localparam logic [3:0] START_RST    = 4'd7;

  localparam logic [7:0] STEP_TABLE [STEP_COUNT] = '{
    8'd0, 8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd70, 8'd100, 8'd130, 8'd160, 8'd200
  };

  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_SET     = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_LOOKBACK = 2'd1,
    CFG_RELOAD   = 2'd2,
    CFG_MAXTRIES = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_TOUCH,
    S_EXEC,
    S_ADJ_START,
    S_ADJ_READ,
    S_ADJ_ACC,
    S_ADJ_APPLY,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_WRAP,
    CMD_TOUCH,
    CMD_EXEC,
    CMD_ADJ_START,
    CMD_ADJ_READ,
    CMD_ADJ_ACC,
    CMD_ADJ_APPLY,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] bus;
    logic [3:0] try_count;
    logic       succeeded;
    logic       retryable;
    logic [9:0] multiplier_hundredths;
  } in_t;

  typedef struct packed {
    logic [7:0] sleep_hundredths;
    logic [3:0] current_step;
    logic [3:0] active_retry_step;
    logic       failure_seen;
  } out_t;

  typedef struct packed {
    logic wrap_pending;
    logic go_adjust;
    logic adj_more;
  } status_t;

  // First table entry at or above the request; requests above the top give step 10.
  function automatic logic [3:0] step_of(input logic [9:0] mult);
    logic [3:0] res;
    res = TOP_STEP;
    for (int i = STEP_COUNT - 1; i >= 0; i--) begin
      if ({2'b00, STEP_TABLE[i]} >= mult) begin
        res = 4'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/abdst_ctrl.sv */
// Controller state machine sequencing one transaction through the datapath.
`default_nettype none
module abdst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire abdst_pkg::status_t status,
  output abdst_pkg::cmd_t        cmd,
  output logic                   busy
);
  import abdst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (start) state_next = S_WRAP;
      S_WRAP:      if (!status.wrap_pending) state_next = S_TOUCH;
      S_TOUCH:     state_next = S_EXEC;
      S_EXEC:      state_next = status.go_adjust ? S_ADJ_START : S_FINISH;
      S_ADJ_START: state_next = S_ADJ_READ;
      S_ADJ_READ:  state_next = status.adj_more ? S_ADJ_ACC : S_ADJ_APPLY;
      S_ADJ_ACC:   state_next = S_ADJ_READ;
      S_ADJ_APPLY: state_next = S_FINISH;
      S_FINISH:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:      cmd = start ? CMD_LOAD : CMD_NONE;
      S_WRAP:      cmd = CMD_WRAP;
      S_TOUCH:     cmd = CMD_TOUCH;
      S_EXEC:      cmd = CMD_EXEC;
      S_ADJ_START: cmd = CMD_ADJ_START;
      S_ADJ_READ:  cmd = CMD_ADJ_READ;
      S_ADJ_ACC:   cmd = CMD_ADJ_ACC;
      S_ADJ_APPLY: cmd = CMD_ADJ_APPLY;
      S_FINISH:    cmd = CMD_FINISH;
      default:     cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/abdst_dp.sv */
// Datapath: configuration, per-bus state, history memory and step arithmetic.
`default_nettype none
module abdst_dp #(
  parameter int BUS_COUNT     = abdst_pkg::BUS_COUNT_DEF,
  parameter int HISTORY_DEPTH = abdst_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire abdst_pkg::cmd_t   cmd,
  input  wire abdst_pkg::in_t    request,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [4:0]        cfg_data,
  output abdst_pkg::status_t     status,
  output abdst_pkg::out_t        result,
  output logic                   done
);
  import abdst_pkg::*;

  localparam int BW    = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
  localparam int DEPTH = BUS_COUNT * HISTORY_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int SW    = (CW > 5) ? CW : 5;
  localparam int TW    = $clog2(HISTORY_DEPTH * 15 + 1);
  localparam int XW    = (TW + 4 > 10) ? TW + 4 : 10;

  in_t        req;
  logic [4:0] wrap;
  logic       en;
  logic [4:0] lookback;
  logic [3:0] reload;
  logic [3:0] max_tries;
  logic [3:0] start_step;

  logic          bus_valid     [BUS_COUNT];
  logic [3:0]    learned_step  [BUS_COUNT];
  logic [3:0]    retry_step    [BUS_COUNT];
  logic [3:0]    retry_tries   [BUS_COUNT];
  logic [3:0]    interval_left [BUS_COUNT];
  logic          failure_found [BUS_COUNT];
  logic [NW-1:0] history_next  [BUS_COUNT];
  logic [CW-1:0] history_count [BUS_COUNT];

  logic [3:0]    hist [DEPTH];
  logic [3:0]    rdata;

  logic [CW-1:0] k;
  logic [CW-1:0] n;
  logic [NW-1:0] rp;
  logic [TW-1:0] total;
  logic [3:0]    top;

  logic [BW-1:0] bidx;
  logic [3:0]    lrn, rst_step, rtries, il_dec, sof, cur, rstep_calc, lrn_adj;
  logic [4:0]    remain;
  logic [7:0]    third;
  logic signed [5:0] left;
  logic          ffv, valid_b, rec_en, need_touch, rise;
  logic [NW-1:0] pos, pos_inc, rp_init;
  logic [AW-1:0] base;
  logic [SW-1:0] span;
  logic [CW-1:0] span_c;

  always_comb begin
    bidx     = BW'(wrap);
    valid_b  = bus_valid[bidx];
    lrn      = learned_step[bidx];
    rst_step = retry_step[bidx];
    rtries   = retry_tries[bidx];
    ffv      = failure_found[bidx];
    il_dec   = interval_left[bidx] - 4'd1;
    sof      = step_of(req.multiplier_hundredths);
    rec_en   = (kind_t'(req.kind) == KIND_RECORD) && en;
    need_touch = rec_en || (kind_t'(req.kind) == KIND_QUERY)
                 || (kind_t'(req.kind) == KIND_SET);

    pos     = history_next[bidx];
    pos_inc = (int'(pos) == HISTORY_DEPTH - 1) ? '0 : pos + NW'(1);
    rp_init = (pos == '0) ? NW'(HISTORY_DEPTH - 1) : pos - NW'(1);
    base    = AW'(bidx) * AW'(HISTORY_DEPTH);

    span   = (int'(lookback) < HISTORY_DEPTH) ? SW'(lookback) : SW'(HISTORY_DEPTH);
    span_c = CW'(span);

    // retry step from the tries left
    left   = $signed({2'b00, max_tries}) - $signed({2'b00, req.try_count});
    cur    = (rst_step > TOP_STEP) ? TOP_STEP : rst_step;
    remain = 5'd11 - {1'b0, cur};
    third  = (8'(remain) * 8'd11) >> 5;
    if (left < 6'sd3) begin
      rstep_calc = TOP_STEP;
    end else if (left < 6'sd6) begin
      rstep_calc = 4'(remain >> 1);
    end else begin
      rstep_calc = third[3:0];
    end

    rise = (top > 4'd2)
           || ((span != '0) && (XW'(total) * XW'(4'd10) >= XW'(span) * XW'(3'd6)));
    if (rise) begin
      lrn_adj = (lrn < TOP_STEP) ? lrn + 4'd1 : lrn;
    end else if (!ffv && lrn != 4'd0) begin
      lrn_adj = lrn - 4'd1;
    end else begin
      lrn_adj = lrn;
    end

    status.wrap_pending = (int'(wrap) >= BUS_COUNT);
    status.go_adjust    = rec_en && req.succeeded && (rtries == 4'd2) && (il_dec == 4'd0);
    status.adj_more     = (k < n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en         <= ENABLE_RST;
      lookback   <= LOOKBACK_RST;
      reload     <= RELOAD_RST;
      max_tries  <= MAXTRY_RST;
      start_step <= START_RST;
      done       <= 1'b0;
      for (int i = 0; i < BUS_COUNT; i++) begin
        bus_valid[i] <= 1'b0;
      end
    end else begin
      done <= (cmd == CMD_FINISH);
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:   en        <= cfg_data[0];
          CFG_LOOKBACK: lookback  <= cfg_data;
          CFG_RELOAD:   reload    <= cfg_data[3:0];
          CFG_MAXTRIES: max_tries <= cfg_data[3:0];
          default:      en        <= en;
        endcase
      end
      unique case (cmd)
        CMD_LOAD: begin
          req  <= request;
          wrap <= request.bus;
        end
        CMD_WRAP: begin
          if (status.wrap_pending) wrap <= wrap - 5'(BUS_COUNT);
        end
        CMD_TOUCH: begin
          if (need_touch && !valid_b) begin
            bus_valid[bidx]     <= 1'b1;
            learned_step[bidx]  <= start_step;
            retry_step[bidx]    <= start_step;
            retry_tries[bidx]   <= 4'd0;
            interval_left[bidx] <= reload;
            failure_found[bidx] <= 1'b0;
            history_next[bidx]  <= '0;
            history_count[bidx] <= '0;
          end
        end
        CMD_EXEC: begin
          unique case (kind_t'(req.kind))
            KIND_RECORD: begin
              if (en && req.succeeded) begin
                history_next[bidx] <= pos_inc;
                if (int'(history_count[bidx]) < HISTORY_DEPTH) begin
                  history_count[bidx] <= history_count[bidx] + CW'(1);
                end
                if (rtries > 4'd2) begin
                  learned_step[bidx]  <= rst_step;
                  failure_found[bidx] <= 1'b1;
                  retry_tries[bidx]   <= 4'd0;
                end else if (rtries == 4'd2 && il_dec == 4'd0) begin
                  // adjustment follows; it finishes the retry bookkeeping
                  interval_left[bidx] <= reload;
                end else begin
                  if (rtries == 4'd2) interval_left[bidx] <= il_dec;
                  retry_tries[bidx] <= 4'd0;
                  retry_step[bidx]  <= lrn;
                end
              end else if (en && req.retryable) begin
                retry_tries[bidx] <= req.try_count;
                retry_step[bidx]  <= rstep_calc;
              end
            end
            KIND_SET: learned_step[bidx] <= sof;
            KIND_RESTART: begin
              start_step <= sof;
              for (int i = 0; i < BUS_COUNT; i++) begin
                if (bus_valid[i]) begin
                  learned_step[i]  <= sof;
                  failure_found[i] <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        CMD_ADJ_START: begin
          k     <= '0;
          total <= '0;
          top   <= 4'd0;
          rp    <= rp_init;
          n     <= (span_c < history_count[bidx]) ? span_c : history_count[bidx];
        end
        CMD_ADJ_ACC: begin
          total <= total + TW'(rdata);
          if (rdata > top) top <= rdata;
          k  <= k + CW'(1);
          rp <= (rp == '0) ? NW'(HISTORY_DEPTH - 1) : rp - NW'(1);
        end
        CMD_ADJ_APPLY: begin
          learned_step[bidx] <= lrn_adj;
          retry_step[bidx]   <= lrn_adj;
          retry_tries[bidx]  <= 4'd0;
          if (rise) failure_found[bidx] <= 1'b1;
        end
        CMD_FINISH: begin
          result.current_step      <= valid_b ? lrn : start_step;
          result.active_retry_step <= valid_b ? cur : start_step;
          result.sleep_hundredths  <= STEP_TABLE[valid_b ? cur : start_step];
          result.failure_seen      <= valid_b && ffv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EXEC && rec_en && req.succeeded) begin
      hist[base + AW'(pos)] <= req.try_count;
    end
    if (cmd == CMD_ADJ_READ) begin
      rdata <= hist[base + AW'(rp)];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/adaptive_bus_delay_step_tuner.sv */
// Top level of the adaptive bus delay step tuner.
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+-------------------------------
//  request   | start, busy, request          | taken when start && !busy
//  result    | done, result                  | one-cycle strobe, never held
//  config    | cfg_we, cfg_index, cfg_data   | written when cfg_we is high
//
// A transaction passes the wrap, touch, execute and finish states before the done
// strobe, the wrap state once more per wrap of an out-of-range bus number and, when
// an adjustment runs, the adjust states for n history entries (at most 20 by default):
// the history memory has one registered read port and is read one entry at a time.
// busy drops in the cycle of the done strobe, so the next transaction can start there.
// Reset is synchronous and clears configuration, start step and all bus valid bits;
// per-bus stores fill on first touch and history is read only once written: no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module adaptive_bus_delay_step_tuner #(
  parameter int BUS_COUNT     = abdst_pkg::BUS_COUNT_DEF,
  parameter int HISTORY_DEPTH = abdst_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire abdst_pkg::in_t request,
  output logic                done,
  output abdst_pkg::out_t     result,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [4:0]     cfg_data
);
  import abdst_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequence each transaction: wrap bus, touch, execute, optional adjust, report
  abdst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // hold all per-bus state and the history ring
  abdst_dp #(
    .BUS_COUNT     (BUS_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule
`default_nettype wire

/* verif/adaptive_bus_delay_step_tuner_tb.sv */
// Self-checking testbench for the adaptive bus delay step tuner.
`default_nettype none
module adaptive_bus_delay_step_tuner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import abdst_pkg::*;

  localparam int BUSES = 32;
  localparam int DEPTH = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [3:0] MAX_STEP = 4'd10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t request = '0;
  logic done;
  out_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  adaptive_bus_delay_step_tuner DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the tuner's registers and per-bus state.
  logic       sh_enable;
  logic [4:0] sh_lookback;
  logic [3:0] sh_reload, sh_max_tries, sh_start;
  logic       sh_valid [BUSES];
  logic [3:0] sh_learned [BUSES];
  logic [3:0] sh_retry [BUSES];
  logic [3:0] sh_rtries [BUSES];
  logic [3:0] sh_left [BUSES];
  logic       sh_fail [BUSES];
  logic [3:0] sh_hist [BUSES][DEPTH];
  logic [4:0] sh_hnext [BUSES];
  logic [4:0] sh_hcount [BUSES];

  in_t  pending_requests[$];
  out_t expected_results[$];
  int   mismatches = 0;
  int   idle_pct = 7;
  int   quiet_cycles = 0;
  bit   timed_out = 1'b0;

  // busy as sampled at the last rising edge, so acceptance is decided per edge.
  logic busy_seen = 1'b1;

  function automatic logic [3:0] mult_to_step(logic [9:0] m);
    logic [7:0] tbl [11];
    tbl = '{8'd0, 8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd70, 8'd100, 8'd130, 8'd160, 8'd200};
    for (int i = 0; i < 11; i++) begin
      if ({2'b00, tbl[i]} >= m) return 4'(i);
    end
    return MAX_STEP;
  endfunction

  function automatic logic [7:0] step_to_sleep(logic [3:0] s);
    logic [7:0] tbl [11];
    tbl = '{8'd0, 8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd70, 8'd100, 8'd130, 8'd160, 8'd200};
    return tbl[s > MAX_STEP ? MAX_STEP : s];
  endfunction

  function automatic void bring_up_bus(int b);
    if (sh_valid[b]) return;
    sh_valid[b] = 1'b1;
    sh_learned[b] = sh_start;
    sh_retry[b] = sh_start;
    sh_rtries[b] = '0;
    sh_left[b] = sh_reload;
    sh_fail[b] = 1'b0;
    sh_hnext[b] = '0;
    sh_hcount[b] = '0;
  endfunction

  // Look at the newest history entries and move the learned step.
  function automatic void tune_step(int b);
    int span, n, total, top, t, pos;
    bit rise;
    span = sh_lookback < DEPTH ? sh_lookback : DEPTH;
    n = span < sh_hcount[b] ? span : sh_hcount[b];
    total = 0;
    top = 0;
    for (int k = 0; k < n; k++) begin
      pos = (sh_hnext[b] + DEPTH - 1 - k) % DEPTH;
      t = sh_hist[b][pos];
      total += t;
      if (t > top) top = t;
    end
    rise = top > 2 || (span != 0 && (total * 10) / span > 5);
    if (rise) begin
      if (sh_learned[b] < MAX_STEP) sh_learned[b]++;
      sh_fail[b] = 1'b1;
    end else if (!sh_fail[b] && sh_learned[b] > 0) begin
      sh_learned[b]--;
    end
  endfunction

  function automatic void log_outcome(int b, logic [3:0] tries, logic ok, logic may_retry);
    int pos, left, cur;
    if (ok) begin
      pos = sh_hnext[b] % DEPTH;
      sh_hist[b][pos] = tries;
      sh_hnext[b] = 5'((pos + 1) % DEPTH);
      if (sh_hcount[b] < DEPTH) sh_hcount[b]++;
      if (sh_rtries[b] > 2) begin
        sh_learned[b] = sh_retry[b];
        sh_fail[b] = 1'b1;
      end else if (sh_rtries[b] == 2) begin
        sh_left[b] = sh_left[b] - 4'd1;
        if (sh_left[b] == 0) begin
          tune_step(b);
          sh_left[b] = sh_reload;
        end
      end
      sh_rtries[b] = '0;
      sh_retry[b] = sh_learned[b];
    end else if (may_retry) begin
      left = int'(sh_max_tries) - int'(tries);
      cur = sh_retry[b] > MAX_STEP ? MAX_STEP : sh_retry[b];
      sh_rtries[b] = tries;
      if (left < 3) sh_retry[b] = MAX_STEP;
      else if (left < 6) sh_retry[b] = 4'((11 - cur) / 2);
      else sh_retry[b] = 4'((11 - cur) / 3);
    end
  endfunction

  function automatic out_t predict_bus_report(in_t rq);
    out_t o;
    int b;
    logic [3:0] rs;
    b = rq.bus % BUSES;
    case (kind_t'(rq.kind))
      KIND_RECORD: begin
        if (sh_enable) begin
          bring_up_bus(b);
          log_outcome(b, rq.try_count, rq.succeeded, rq.retryable);
        end
      end
      KIND_QUERY: bring_up_bus(b);
      KIND_SET: begin
        bring_up_bus(b);
        sh_learned[b] = mult_to_step(rq.multiplier_hundredths);
      end
      default: begin
        sh_start = mult_to_step(rq.multiplier_hundredths);
        for (int i = 0; i < BUSES; i++) begin
          if (sh_valid[i]) begin
            sh_learned[i] = sh_start;
            sh_fail[i] = 1'b0;
          end
        end
      end
    endcase
    if (sh_valid[b]) begin
      o.current_step = sh_learned[b];
      rs = sh_retry[b];
      o.failure_seen = sh_fail[b];
    end else begin
      o.current_step = sh_start;
      rs = sh_start;
      o.failure_seen = 1'b0;
    end
    if (rs > MAX_STEP) rs = MAX_STEP;
    o.active_retry_step = rs;
    o.sleep_hundredths = step_to_sleep(rs);
    return o;
  endfunction

  // Driver: present the next pending transaction at the falling edge; hold it until taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_seen) begin
        // previous transaction was accepted at the last rising edge
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          request <= pending_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          request <= pending_requests.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: predict on acceptance, check each done strobe.
  always @(posedge clk) begin
    out_t exp_o;
    busy_seen <= busy;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) expected_results.push_back(predict_bus_report(request));
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          exp_o = expected_results.pop_front();
          if (result !== exp_o) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_o, result);
          end
        end
      end
      if ((start && !busy) || done) quiet_cycles <= 0;
      else if (pending_requests.size() > 0 || expected_results.size() > 0 || start)
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain_and_settle();
    while (pending_requests.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    // a transaction in flight always yields a result, so a short settle suffices
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: sh_enable = val[0];
      CFG_LOOKBACK: sh_lookback = val;
      CFG_RELOAD: sh_reload = val[3:0];
      default: sh_max_tries = val[3:0];
    endcase
  endtask

  function automatic in_t make_req(kind_t k, int b, int tries, bit ok, bit rt, int m);
    in_t r;
    r.kind = k;
    r.bus = 5'(b);
    r.try_count = 4'(tries);
    r.succeeded = ok;
    r.retryable = rt;
    r.multiplier_hundredths = 10'(m);
    return r;
  endfunction

  // Mostly realistic transfer sequences on a few buses: retries then a success.
  task automatic queue_random_traffic(int count);
    int b, tries, sel;
    for (int i = 0; i < count; i++) begin
      b = $urandom_range(99) < 80 ? $urandom_range(3) : $urandom_range(31);
      sel = $urandom_range(99);
      if (sel < 55) begin
        tries = $urandom_range(99) < 50 ? 2 : $urandom_range(15);
        pending_requests.push_back(make_req(KIND_RECORD, b, tries, 1'b0, 1'b1, 0));
        pending_requests.push_back(make_req(KIND_RECORD, b, $urandom_range(99) < 60 ? 2 :
                                            $urandom_range(15), 1'b1, 1'b0, 0));
        i++;
      end else if (sel < 75) begin
        pending_requests.push_back(make_req(KIND_RECORD, b, $urandom_range(15),
                                            1'($urandom_range(1)), 1'($urandom_range(1)),
                                            $urandom_range(1023)));
      end else if (sel < 88) begin
        pending_requests.push_back(make_req(KIND_QUERY, b, $urandom_range(15),
                                            1'($urandom_range(1)), 1'($urandom_range(1)),
                                            $urandom_range(1023)));
      end else if (sel < 97) begin
        pending_requests.push_back(make_req(KIND_SET, b, $urandom_range(15),
                                            1'($urandom_range(1)), 1'($urandom_range(1)),
                                            $urandom_range(1023)));
      end else begin
        pending_requests.push_back(make_req(KIND_RESTART, b, $urandom_range(15),
                                            1'($urandom_range(1)), 1'($urandom_range(1)),
                                            $urandom_range(1023)));
      end
    end
  endtask

  initial begin
    sh_enable = ENABLE_RST;
    sh_lookback = LOOKBACK_RST;
    sh_reload = RELOAD_RST;
    sh_max_tries = MAXTRY_RST;
    sh_start = START_RST;
    for (int i = 0; i < BUSES; i++) sh_valid[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: disabled record and restart leave buses untouched, then the extremes.
    pending_requests.push_back(make_req(KIND_RECORD, 31, 15, 1'b1, 1'b1, 1023));
    pending_requests.push_back(make_req(KIND_RESTART, 0, 0, 1'b0, 1'b0, 1000));
    pending_requests.push_back(make_req(KIND_QUERY, 31, 0, 1'b0, 1'b0, 0));
    pending_requests.push_back(make_req(KIND_SET, 5, 0, 1'b0, 1'b0, 201));
    pending_requests.push_back(make_req(KIND_SET, 6, 0, 1'b0, 1'b0, 0));
    pending_requests.push_back(make_req(KIND_SET, 7, 0, 1'b0, 1'b0, 51));
    pending_requests.push_back(make_req(KIND_RESTART, 9, 0, 1'b0, 1'b0, 70));
    drain_and_settle();
    write_reg(CFG_ENABLE, 5'd1);
    write_reg(CFG_RELOAD, 5'd1);
    // Retry steps from each tries-left band, non-retryable failure, long and two-try success.
    pending_requests.push_back(make_req(KIND_RECORD, 1, 9, 1'b0, 1'b1, 0));
    pending_requests.push_back(make_req(KIND_RECORD, 1, 5, 1'b0, 1'b1, 0));
    pending_requests.push_back(make_req(KIND_RECORD, 1, 0, 1'b0, 1'b1, 0));
    pending_requests.push_back(make_req(KIND_RECORD, 1, 15, 1'b0, 1'b1, 0));
    pending_requests.push_back(make_req(KIND_RECORD, 1, 3, 1'b0, 1'b0, 0));
    pending_requests.push_back(make_req(KIND_RECORD, 1, 4, 1'b1, 1'b0, 0));
    for (int i = 0; i < 4; i++) begin
      pending_requests.push_back(make_req(KIND_RECORD, 2, 2, 1'b0, 1'b1, 0));
      pending_requests.push_back(make_req(KIND_RECORD, 2, i == 3 ? 3 : 0, 1'b1, 1'b0, 0));
    end
    pending_requests.push_back(make_req(KIND_RESTART, 2, 0, 1'b0, 1'b0, 200));
    drain_and_settle();

    // Random phases over several register settings, extremes included.
    write_reg(CFG_LOOKBACK, 5'd20);
    write_reg(CFG_RELOAD, 5'd0);
    write_reg(CFG_MAXTRIES, 5'd15);
    queue_random_traffic(210);
    drain_and_settle();
    write_reg(CFG_LOOKBACK, 5'd1);
    write_reg(CFG_RELOAD, 5'd15);
    write_reg(CFG_MAXTRIES, 5'd1);
    queue_random_traffic(140);
    drain_and_settle();
    idle_pct = 78;
    write_reg(CFG_LOOKBACK, 5'd31);
    write_reg(CFG_RELOAD, 5'd2);
    write_reg(CFG_MAXTRIES, 5'd7);
    queue_random_traffic(200);
    drain_and_settle();
    idle_pct = 0;
    write_reg(CFG_LOOKBACK, 5'd0);
    write_reg(CFG_RELOAD, 5'd1);
    write_reg(CFG_MAXTRIES, 5'd0);
    queue_random_traffic(100);
    drain_and_settle();
    write_reg(CFG_LOOKBACK, 5'd4);
    write_reg(CFG_MAXTRIES, 5'd10);
    queue_random_traffic(150);
    drain_and_settle();
    write_reg(CFG_ENABLE, 5'd0);
    queue_random_traffic(30);
    drain_and_settle();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/abdst_pkg.sv
hw/rtl/abdst_ctrl.sv
hw/rtl/abdst_dp.sv
hw/rtl/adaptive_bus_delay_step_tuner.sv
verif/adaptive_bus_delay_step_tuner_tb.sv
